// ===== rtl/lfit_pkg.sv =====
// Shared types and constants for the line framer with idle timeout.
// Used by lfit_ctrl, lfit_dp and line_framer_idle_timeout_top; no dependencies.
package lfit_pkg;

  // Default line store depth (entries), and field widths
  localparam int FRAME_DEPTH_DEF = 64;
  localparam int OP_W            = 2;
  localparam int BYTE_W          = 8;
  localparam int LIMIT_W         = 8;
  localparam int TICK_W          = 16;
  localparam int CHAR_W          = 7;
  localparam int IDX_W           = 6;

  // Item opcodes
  localparam logic [OP_W-1:0] OP_BYTE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  // Register reset value and byte classes
  localparam logic [TICK_W-1:0] IDLE_RESET = 16'd30;
  localparam logic [BYTE_W-1:0] PRINT_LO   = 8'h20;
  localparam logic [BYTE_W-1:0] PRINT_HI   = 8'h7E;
  localparam logic [BYTE_W-1:0] CH_NL      = 8'h0A;

  // Commands from controller to datapath
  typedef struct packed {
    logic byte_en;      // take rx_byte into the line
    logic tick_en;      // advance the tick counter
    logic read_latch;   // capture read_limit
    logic emit_summary; // emit one summary word (not ready, or nothing to copy)
    logic start_stream; // reset char index, fetch first char
    logic emit_char;    // emit one character word
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic rd_ready;  // read condition holds
    logic n_zero;    // nothing to copy
    logic last_char; // current char index is the final one
  } status_t;

endpackage

// ===== rtl/lfit_ctrl.sv =====
// Controller state machine for the line framer: sequences byte, tick and read items.
// Depends on lfit_pkg (cmd_t, status_t, opcodes).
module lfit_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lfit_pkg::OP_W-1:0]     opcode,
  input  lfit_pkg::status_t             status,
  output lfit_pkg::cmd_t                cmd,
  output logic                          busy
);

  typedef enum logic [1:0] {
    IDLE,
    EVAL,
    STREAM
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (start) begin
          case (opcode)
            lfit_pkg::OP_BYTE: cmd.byte_en = 1'b1;
            lfit_pkg::OP_TICK: cmd.tick_en = 1'b1;
            lfit_pkg::OP_READ: begin
              cmd.read_latch = 1'b1;
              state_next     = EVAL;
            end
            default: ;
          endcase
        end
      end
      EVAL: begin
        if (!status.rd_ready || status.n_zero) begin
          cmd.emit_summary = 1'b1;
          state_next       = IDLE;
        end else begin
          cmd.start_stream = 1'b1;
          state_next       = STREAM;
        end
      end
      STREAM: begin
        cmd.emit_char = 1'b1;
        if (status.last_char) begin
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  // State and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != IDLE);
    end
  end

endmodule

// ===== rtl/lfit_dp.sv =====
// Datapath for the line framer: tick/timeout registers, line store memory,
// read evaluation and registered result word. Depends on lfit_pkg.
module lfit_dp #(
  parameter int FRAME_DEPTH = lfit_pkg::FRAME_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lfit_pkg::cmd_t                  cmd,
  output lfit_pkg::status_t               status,
  input  logic [lfit_pkg::BYTE_W-1:0]     rx_byte,
  input  logic [lfit_pkg::LIMIT_W-1:0]    read_limit,
  input  logic                            cfg_we,
  input  logic [lfit_pkg::TICK_W-1:0]     cfg_data,
  output logic                            result_strobe,
  output logic                            frame_ready,
  output logic                            char_valid,
  output logic [lfit_pkg::CHAR_W-1:0]     data_char,
  output logic [lfit_pkg::IDX_W-1:0]      char_index,
  output logic [lfit_pkg::IDX_W-1:0]      frame_length,
  output logic                            last
);

  localparam int CW = $clog2(FRAME_DEPTH);
  localparam logic [CW-1:0] COUNT_MAX = CW'(FRAME_DEPTH - 1);

  logic [lfit_pkg::TICK_W-1:0]  idle_timeout_ms;
  logic [lfit_pkg::TICK_W-1:0]  tick_count;
  logic [lfit_pkg::TICK_W-1:0]  last_rx_tick;
  logic                         line_done;
  logic [CW-1:0]                char_count;
  logic [lfit_pkg::LIMIT_W-1:0] limit_q;
  logic [CW-1:0]                idx;
  logic [lfit_pkg::CHAR_W-1:0]  line_store [FRAME_DEPTH];
  logic [lfit_pkg::CHAR_W-1:0]  mem_q;

  logic [lfit_pkg::TICK_W-1:0]  gap;
  logic                         printable;
  logic                         appending;
  logic [CW-1:0]                n_chars;
  logic [CW-1:0]                idx_inc;
  logic [CW-1:0]                rd_addr;
  logic                         clear_line;

  // Read evaluation: wrapping gap and copy length
  assign gap       = tick_count - last_rx_tick;
  assign printable = (rx_byte >= lfit_pkg::PRINT_LO) && (rx_byte <= lfit_pkg::PRINT_HI);
  assign appending = cmd.byte_en && printable && (char_count < COUNT_MAX);

  always_comb begin
    if (lfit_pkg::LIMIT_W'(char_count) >= limit_q) begin
      n_chars = CW'(limit_q - 1'b1);
    end else begin
      n_chars = char_count;
    end
  end

  assign status.rd_ready  = (limit_q != '0) &&
                            (line_done || ((char_count != '0) && (gap >= idle_timeout_ms)));
  assign status.n_zero    = (n_chars == '0);
  assign idx_inc          = idx + 1'b1;
  assign status.last_char = (idx_inc == n_chars);

  assign rd_addr    = cmd.start_stream ? '0 : idx_inc;
  assign clear_line = (cmd.emit_summary && status.rd_ready) ||
                      (cmd.emit_char && status.last_char);

  // Control registers: timeout, ticks, line status
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout_ms <= lfit_pkg::IDLE_RESET;
      tick_count      <= '0;
      last_rx_tick    <= '0;
      line_done       <= 1'b0;
      char_count      <= '0;
    end else begin
      if (cfg_we) begin
        idle_timeout_ms <= cfg_data;
      end
      if (cmd.tick_en) begin
        tick_count <= tick_count + 1'b1;
      end
      if (cmd.byte_en) begin
        last_rx_tick <= tick_count;
        if (rx_byte == lfit_pkg::CH_NL) begin
          line_done <= 1'b1;
        end else if (printable) begin
          if (appending) begin
            char_count <= char_count + 1'b1;
          end else begin
            line_done <= 1'b1;
          end
        end
      end
      if (clear_line) begin
        char_count <= '0;
        line_done  <= 1'b0;
      end
    end
  end

  // Read limit and stream index
  always_ff @(posedge clk) begin
    if (cmd.read_latch) begin
      limit_q <= read_limit;
    end
    if (cmd.start_stream) begin
      idx <= '0;
    end else if (cmd.emit_char) begin
      idx <= idx_inc;
    end
  end

  // Line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (appending) begin
      line_store[char_count] <= rx_byte[lfit_pkg::CHAR_W-1:0];
    end
    mem_q <= line_store[rd_addr];
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit_summary || cmd.emit_char;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (cmd.emit_summary) begin
      frame_ready  <= status.rd_ready;
      char_valid   <= 1'b0;
      data_char    <= '0;
      char_index   <= '0;
      frame_length <= '0;
      last         <= 1'b1;
    end else if (cmd.emit_char) begin
      frame_ready  <= 1'b1;
      char_valid   <= 1'b1;
      data_char    <= mem_q;
      char_index   <= lfit_pkg::IDX_W'(idx);
      frame_length <= lfit_pkg::IDX_W'(n_chars);
      last         <= status.last_char;
    end
  end

endmodule

// ===== rtl/line_framer_idle_timeout_top.sv =====
// Top level of the line framer with idle timeout.
// Joins lfit_ctrl and lfit_dp; depends on lfit_pkg.
//
// Usage:
//   Items arrive on start with opcode, rx_byte and read_limit, and are taken
//   at a clock edge where start is high and busy is low. A byte or a tick
//   item produces no word; busy stays low, so these can come every cycle.
//   Opcode three is ignored.
//   A read item passes through an evaluation state, then streams its characters
//   out of the line store in the STREAM state (its single registered read port
//   sets the pace). A read holds busy through evaluation when it returns a
//   summary word, and through the stream as well when it returns characters.
//   Each result word appears on the result ports for exactly one cycle with
//   result_strobe high, in the cycle after it is formed in the datapath; the
//   receiver cannot stall, and the block may take its next item while the
//   final word of a read is still on the ports.
//   Timeout register writes use cfg_valid/cfg_data; cfg_ready is always high.
//   The user must write only while no item is in progress (not enforced).
//   Synchronous reset clears the tick counters, line status and controller,
//   and loads the timeout with its default; the line store is not cleared.
module line_framer_idle_timeout_top #(
  parameter int FRAME_DEPTH = lfit_pkg::FRAME_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [lfit_pkg::OP_W-1:0]       opcode,
  input  logic [lfit_pkg::BYTE_W-1:0]     rx_byte,
  input  logic [lfit_pkg::LIMIT_W-1:0]    read_limit,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lfit_pkg::TICK_W-1:0]     cfg_data,
  output logic                            result_strobe,
  output logic                            frame_ready,
  output logic                            char_valid,
  output logic [lfit_pkg::CHAR_W-1:0]     data_char,
  output logic [lfit_pkg::IDX_W-1:0]      char_index,
  output logic [lfit_pkg::IDX_W-1:0]      frame_length,
  output logic                            last
);

  lfit_pkg::cmd_t    cmd;
  lfit_pkg::status_t status;

  assign cfg_ready = 1'b1;

  lfit_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  lfit_dp #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .rx_byte       (rx_byte),
    .read_limit    (read_limit),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .frame_ready   (frame_ready),
    .char_valid    (char_valid),
    .data_char     (data_char),
    .char_index    (char_index),
    .frame_length  (frame_length),
    .last          (last)
  );

endmodule
